### src/assert_macros.svh
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, disabled during reset
`define ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("assertion failed");
// Next-cycle implication, disabled during reset
`define ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("assertion failed");
`endif

### src/sed_pkg.sv
// ----------------------------------------------------------------------------
// sed_pkg
// Types, constants and the exponent table of the softmax expectation decoder.
// ----------------------------------------------------------------------------
package sed_pkg;
    localparam int MAX_BINS  = 16;
    localparam int VALUE_W   = 16;
    localparam int IDX_W     = 4;
    localparam int CNT_W     = 5;
    localparam int T_W       = 21;
    localparam int E_W       = 17;
    localparam int SUM_W     = 21;
    localparam int PROD_W    = 34;
    localparam int ACC_W     = 38;
    localparam int DIV_W     = 38;
    localparam int DCNT_W    = 6;
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic       CMD_WEIGHT = 1'b0;
    localparam logic       CMD_LOGIT  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL1, S_EXP, S_MUL2, S_ACC, S_DIVI, S_DIV, S_DONE
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic mul1;
        logic expo;
        logic mul2;
        logic acc;
        logic div_init;
        logic div_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic completes;
        logic last_bin;
        logic div_last;
        logic out_free;
    } t_status;

    // 2^(-j/16) in Q16
    function automatic logic [16:0] pow2_neg(input logic [4:0] j);
        logic [16:0] p;
        unique case (j)
            5'd0:  p = 17'd65536;
            5'd1:  p = 17'd62757;
            5'd2:  p = 17'd60097;
            5'd3:  p = 17'd57549;
            5'd4:  p = 17'd55109;
            5'd5:  p = 17'd52773;
            5'd6:  p = 17'd50535;
            5'd7:  p = 17'd48393;
            5'd8:  p = 17'd46341;
            5'd9:  p = 17'd44376;
            5'd10: p = 17'd42495;
            5'd11: p = 17'd40693;
            5'd12: p = 17'd38968;
            5'd13: p = 17'd37316;
            5'd14: p = 17'd35734;
            5'd15: p = 17'd34219;
            default: p = 17'd32768;
        endcase
        return p;
    endfunction
endpackage

### src/sed_in_if.sv
// ----------------------------------------------------------------------------
// sed_in_if
// Input channel: weight writes and bin logits.
// ----------------------------------------------------------------------------
interface sed_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [3:0]  weight_index;
    logic signed [15:0] value;
    modport source (output valid, command, weight_index, value, input ready);
    modport sink   (input valid, command, weight_index, value, output ready);
endinterface

### src/sed_out_if.sv
// ----------------------------------------------------------------------------
// sed_out_if
// Output channel: decoded expectation and saturation flag.
// ----------------------------------------------------------------------------
interface sed_out_if;
    logic        valid;
    logic        ready;
    logic signed [15:0] expectation;
    logic        saturated;
    modport source (output valid, expectation, saturated, input ready);
    modport sink   (input valid, expectation, saturated, output ready);
endinterface

### src/sed_ctrl.sv
// ----------------------------------------------------------------------------
// sed_ctrl
// Sequencer: accept beats, walk the bins, run the divider, hand off result.
// ----------------------------------------------------------------------------
module sed_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sed_pkg::t_status i_status,
    output sed_pkg::t_cmd    o_cmd
);
    import sed_pkg::*;

    t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_status.completes) n_state = S_MUL1;
            S_MUL1: n_state = S_EXP;
            S_EXP:  n_state = S_MUL2;
            S_MUL2: n_state = S_ACC;
            S_ACC:  n_state = i_status.last_bin ? S_DIVI : S_MUL1;
            S_DIVI: n_state = S_DIV;
            S_DIV:  if (i_status.div_last) n_state = S_DONE;
            S_DONE: if (i_status.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd          = '0;
        o_cmd.in_ready = (r_state == S_IDLE);
        o_cmd.mul1     = (r_state == S_MUL1);
        o_cmd.expo     = (r_state == S_EXP);
        o_cmd.mul2     = (r_state == S_MUL2);
        o_cmd.acc      = (r_state == S_ACC);
        o_cmd.div_init = (r_state == S_DIVI);
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.load_out = (r_state == S_DONE) && i_status.out_free;
    end
endmodule

### src/sed_dp.sv
// ----------------------------------------------------------------------------
// sed_dp
// Datapath: weight table, logit buffer, exponent, accumulators, divider.
// ----------------------------------------------------------------------------
module sed_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [4:0]         i_bins_in_use,
    input  sed_pkg::t_cmd      i_cmd,
    output sed_pkg::t_status   o_status,
    sed_in_if.sink             i_in,
    sed_out_if.source          o_out
);
    import sed_pkg::*;

    logic signed [VALUE_W-1:0] r_weights [MAX_BINS];
    logic signed [VALUE_W-1:0] r_logits  [MAX_BINS];
    logic [CNT_W-1:0]          r_rcv;
    logic signed [VALUE_W-1:0] r_max;
    logic signed [VALUE_W-1:0] r_wmax;
    logic [CNT_W-1:0]          r_n;
    logic [IDX_W-1:0]          r_idx;
    logic [T_W-1:0]            r_t;
    logic [E_W-1:0]            r_e;
    logic signed [PROD_W-1:0]  r_prod;
    logic [SUM_W-1:0]          r_sum;
    logic signed [ACC_W-1:0]   r_acc;
    logic [DIV_W-1:0]          r_num;
    logic [SUM_W-1:0]          r_rem;
    logic [DCNT_W-1:0]         r_dcnt;
    logic                      r_neg;
    logic                      r_ov;
    logic signed [VALUE_W-1:0] r_exp_out;
    logic                      r_sat;

    logic [CNT_W-1:0]          need;
    logic [CNT_W-1:0]          rcv_inc;
    logic                      accept;
    logic signed [VALUE_W-1:0] new_max;
    logic [VALUE_W:0]          diff;
    logic [PROD_W-1:0]         t_prod;
    logic [16:0]               p_lo, p_hi, m;
    logic [11:0]               p_step;
    logic [20:0]               step_r;
    logic [E_W-1:0]            e_val;
    logic [ACC_W-1:0]          mag;
    logic [SUM_W:0]            rem_sh;
    logic                      q_bit;

    // Effective bin count and handshake
    always_comb begin
        if (i_bins_in_use == '0)                     need = CNT_W'(1);
        else if (i_bins_in_use > CNT_W'(MAX_BINS))   need = CNT_W'(MAX_BINS);
        else                                         need = i_bins_in_use;
        rcv_inc  = r_rcv + CNT_W'(1);
        accept   = i_in.valid && i_cmd.in_ready;
        new_max  = (i_in.value > r_max) ? i_in.value : r_max;
    end

    assign i_in.ready         = i_cmd.in_ready;
    assign o_status.completes = accept && (i_in.command == CMD_LOGIT) && (rcv_inc >= need);
    assign o_status.last_bin  = ({1'b0, r_idx} + CNT_W'(1)) == r_n;
    assign o_status.div_last  = (r_dcnt == '0);
    assign o_status.out_free  = !r_ov || o_out.ready;

    // Exponent: scale by log2(e), then table interpolation and shift
    always_comb begin
        diff   = {r_wmax[VALUE_W-1], r_wmax} - {r_logits[r_idx][VALUE_W-1], r_logits[r_idx]};
        t_prod = PROD_W'(diff[VALUE_W-1:0]) * PROD_W'(LOG2E_Q16) + PROD_W'(2048);
        p_lo   = pow2_neg({1'b0, r_t[11:8]});
        p_hi   = pow2_neg({1'b0, r_t[11:8]} + 5'd1);
        p_step = 12'(p_lo - p_hi);
        step_r = 21'(p_step) * 21'(r_t[7:0]) + 21'd128;
        m      = p_lo - 17'(step_r[20:8]);
        e_val  = (r_t[T_W-1:12] >= 9'd32) ? '0 : (m >> r_t[16:12]);
    end

    // Divider step: shift in one numerator bit, trial subtract
    always_comb begin
        mag    = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
        rem_sh = {r_rem, r_num[DIV_W-1]};
        q_bit  = rem_sh >= {1'b0, r_sum};
    end

    // Weight table and per-anchor control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < MAX_BINS; b++) r_weights[b] <= '0;
            r_rcv <= '0;
            r_max <= {1'b1, {(VALUE_W-1){1'b0}}};
        end else if (accept) begin
            if (i_in.command == CMD_WEIGHT) begin
                r_weights[i_in.weight_index] <= i_in.value;
            end else if (rcv_inc >= need) begin
                r_rcv <= '0;
                r_max <= {1'b1, {(VALUE_W-1){1'b0}}};
            end else begin
                r_rcv <= rcv_inc;
                r_max <= new_max;
            end
        end
    end

    // Logit buffer and walk datapath
    always_ff @(posedge i_clk) begin
        if (accept && (i_in.command == CMD_LOGIT)) begin
            if (r_rcv < CNT_W'(MAX_BINS)) r_logits[r_rcv[IDX_W-1:0]] <= i_in.value;
            r_wmax <= new_max;
            r_n    <= rcv_inc;
            r_idx  <= '0;
            r_sum  <= '0;
            r_acc  <= '0;
        end
        if (i_cmd.mul1) r_t <= t_prod[T_W+11:12];
        if (i_cmd.expo) r_e <= e_val;
        if (i_cmd.mul2) begin
            r_prod <= PROD_W'($signed({1'b0, r_e}) * r_weights[r_idx]);
            r_sum  <= r_sum + SUM_W'(r_e);
        end
        if (i_cmd.acc) begin
            r_acc <= r_acc + ACC_W'(r_prod);
            r_idx <= r_idx + IDX_W'(1);
        end
        if (i_cmd.div_init) begin
            r_neg  <= r_acc[ACC_W-1];
            r_num  <= DIV_W'(mag) + DIV_W'(r_sum >> 1);
            r_rem  <= '0;
            r_dcnt <= DCNT_W'(DIV_W - 1);
        end
        if (i_cmd.div_step) begin
            r_rem  <= q_bit ? SUM_W'(rem_sh - {1'b0, r_sum}) : SUM_W'(rem_sh);
            r_num  <= {r_num[DIV_W-2:0], q_bit};
            r_dcnt <= r_dcnt - DCNT_W'(1);
        end
    end

    // Output register: clip and hold the beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
        if (i_cmd.load_out) begin
            if (r_neg) begin
                r_sat     <= r_num > DIV_W'(32768);
                r_exp_out <= (r_num > DIV_W'(32768)) ? 16'sh8000
                                                     : VALUE_W'(-r_num[VALUE_W-1:0]);
            end else begin
                r_sat     <= r_num > DIV_W'(32767);
                r_exp_out <= (r_num > DIV_W'(32767)) ? 16'sh7fff
                                                     : VALUE_W'(r_num[VALUE_W-1:0]);
            end
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.expectation = r_exp_out;
    assign o_out.saturated   = r_sat;
endmodule

### src/softmax_expectation_decode.sv
// Sequence: a weight beat goes straight into the table; the completing logit
// beat starts a walk over the bins (multiply, exponent, weight multiply and
// accumulate per bin), then the bit-serial divider (load and 38 steps); the
// result is registered once the output is free. Throughput: one logit beat
// per cycle while bins stream in, then ready is low until the result loads.
// Reset (synchronous, active low): weights zero, bin count 16, anchor cleared.
// ----------------------------------------------------------------------------
// softmax_expectation_decode
// Decodes one anchor's bin distribution into a softmax-weighted distance.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module softmax_expectation_decode (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    sed_in_if.sink      i_in,
    sed_out_if.source   o_out
);
    import sed_pkg::*;

    logic [4:0] r_bins;
    t_cmd       cmd;
    t_status    status;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bins <= 5'd16;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_bins <= pwdata[4:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {27'd0, r_bins};

    sed_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    sed_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_bins_in_use (r_bins),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_in          (i_in),
        .o_out         (o_out)
    );

    // Checks
    `ASSERT_NXT(a_busy_after_last, i_clk, i_rst_n, status.completes, !i_in.ready)
    `ASSERT_IMP(a_sat_clip, i_clk, i_rst_n, o_out.valid && o_out.saturated,
                o_out.expectation == 16'sh7fff || o_out.expectation == 16'sh8000)
endmodule

### tb/sed_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sed_checker
// Watches the input and output channels, predicts each anchor's expectation
// from the weight table and buffered logits, and compares every result beat.
// ----------------------------------------------------------------------------
module sed_checker
    import sed_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [4:0]  i_bins_cfg,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_in_command,
    input  logic [3:0]  i_in_index,
    input  logic [15:0] i_in_value,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [15:0] i_out_expectation,
    input  logic        i_out_saturated,
    output int          o_errors,
    output int          o_pending
);
    typedef struct packed {
        logic [15:0] expectation;
        logic        saturated;
    } t_decoded;

    logic signed [15:0] weight_tab [MAX_BINS];
    logic signed [15:0] logit_tab [MAX_BINS];
    int unsigned        bins_seen;
    logic signed [15:0] peak_logit;
    t_decoded           decoded_q[$];

    // Exponent of -d in Q16, by the table of powers of two
    function automatic longint unsigned exp_of_gap(input longint unsigned d);
        longint unsigned t, ip, m;
        int unsigned     k, r, hi, lo;
        t  = (d * 94548 + 2048) >> 12;
        ip = t >> 12;
        k  = (t >> 8) & 15;
        r  = t & 255;
        hi = pow2_neg(k[4:0]);
        lo = pow2_neg(5'(k + 1));
        m  = hi - (((hi - lo) * r + 128) >> 8);
        return (ip >= 32) ? 0 : (m >> ip);
    endfunction

    function automatic t_decoded decode_anchor(input int unsigned n);
        longint unsigned sum, mag, q, e;
        longint          acc;
        logic            neg;
        t_decoded        res;
        sum = 0;
        acc = 0;
        for (int b = 0; b < n; b++) begin
            e = exp_of_gap(longint'(peak_logit) - longint'(logit_tab[b]));
            sum += e;
            acc += longint'(e) * longint'(weight_tab[b]);
        end
        neg = acc < 0;
        mag = neg ? -acc : acc;
        q = (mag + sum / 2) / sum;
        res.saturated = 1'b0;
        if (neg) begin
            if (q > 32768) begin
                q = 32768;
                res.saturated = 1'b1;
            end
            res.expectation = 16'(-longint'(q));
        end else begin
            if (q > 32767) begin
                q = 32767;
                res.saturated = 1'b1;
            end
            res.expectation = 16'(q);
        end
        return res;
    endfunction

    assign o_pending = decoded_q.size();

    always @(posedge i_clk) begin
        int unsigned need;
        t_decoded    got, exp_r;
        if (!i_rst_n) begin
            foreach (weight_tab[b]) weight_tab[b] = '0;
            bins_seen  = 0;
            peak_logit = 16'sh8000;
            o_errors   = 0;
            decoded_q.delete();
        end else begin
            // Predict from each accepted input beat
            if (i_in_valid && i_in_ready) begin
                if (i_in_command == CMD_WEIGHT) begin
                    weight_tab[i_in_index] = i_in_value;
                end else begin
                    need = i_bins_cfg;
                    if (need < 1) need = 1;
                    if (need > MAX_BINS) need = MAX_BINS;
                    if (bins_seen < MAX_BINS) logit_tab[bins_seen] = i_in_value;
                    if ($signed(i_in_value) > peak_logit) peak_logit = i_in_value;
                    bins_seen++;
                    if (bins_seen >= need) begin
                        decoded_q.push_back(decode_anchor(
                            bins_seen > MAX_BINS ? MAX_BINS : bins_seen));
                        bins_seen  = 0;
                        peak_logit = 16'sh8000;
                    end
                end
            end
            // Compare each accepted result beat
            if (i_out_valid && i_out_ready) begin
                got.expectation = i_out_expectation;
                got.saturated   = i_out_saturated;
                if (decoded_q.size() == 0) begin
                    $error("unexpected result beat: expectation %0d", $signed(got.expectation));
                    o_errors++;
                end else begin
                    exp_r = decoded_q.pop_front();
                    if (got.expectation !== exp_r.expectation) begin
                        $error("expectation: expected %0d, got %0d",
                               $signed(exp_r.expectation), $signed(got.expectation));
                        o_errors++;
                    end
                    if (got.saturated !== exp_r.saturated) begin
                        $error("saturated: expected %0b, got %0b",
                               exp_r.saturated, got.saturated);
                        o_errors++;
                    end
                end
            end
        end
    end
endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives weight writes, logit streams and bin count changes into the decoder
// under varied idling, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb;
    import sed_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 200;
    localparam logic [2:0] ADDR_BINS = 3'd0;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;
    logic [4:0]  bins_cfg;
    int          send_idle_pct, stall_pct;
    int          errors, pending, idle_cycles;

    sed_in_if  in_ch ();
    sed_out_if out_ch ();

    softmax_expectation_decode u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    sed_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_bins_cfg        (bins_cfg),
        .i_in_valid        (in_ch.valid),
        .i_in_ready        (in_ch.ready),
        .i_in_command      (in_ch.command),
        .i_in_index        (in_ch.weight_index),
        .i_in_value        (in_ch.value),
        .i_out_valid       (out_ch.valid),
        .i_out_ready       (out_ch.ready),
        .i_out_expectation (out_ch.expectation),
        .i_out_saturated   (out_ch.saturated),
        .o_errors          (errors),
        .o_pending         (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Random receiver stall
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog on cycles with no accepted beat
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic write_bins(input logic [4:0] n);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BINS;
        pwdata  <= 32'(n);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        bins_cfg = n;
    endtask

    // Send one beat, holding valid until it is accepted
    task automatic send_beat(input logic cmd, input logic [3:0] idx,
                             input logic [15:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.command      <= cmd;
        in_ch.weight_index <= idx;
        in_ch.value        <= val;
        // Look at ready ahead of the edge that takes the beat
        do @(negedge i_clk); while (!in_ch.ready);
        @(posedge i_clk);
    endtask

    task automatic go_idle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Logit with mostly small spread, sometimes full range
    function automatic logic [15:0] rand_logit();
        if ($urandom_range(3) == 0) return 16'($urandom);
        return 16'($signed($urandom_range(4096)) - 2048);
    endfunction

    task automatic random_phase(input int items, input int idle_p, input int stall_p);
        int sent;
        send_idle_pct = idle_p;
        stall_pct     = stall_p;
        sent = 0;
        while (sent < items) begin
            if ($urandom_range(4) == 0) begin
                send_beat(CMD_WEIGHT, 4'($urandom), 16'($urandom));
            end else begin
                for (int b = 0; b < bins_cfg && b < MAX_BINS; b++)
                    send_beat(CMD_LOGIT, 4'($urandom), rand_logit());
                sent += bins_cfg;
            end
            sent++;
        end
        go_idle();
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.command = CMD_WEIGHT;
        in_ch.weight_index = '0;
        in_ch.value = '0;
        out_ch.ready = 1'b1;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        bins_cfg = 5'd16;
        send_idle_pct = 0;
        stall_pct = 0;
        idle_cycles = 0;
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extreme weights, logits and saturation
        write_bins(5'd2);
        send_beat(CMD_WEIGHT, 4'd0, 16'sh7FFF);
        send_beat(CMD_WEIGHT, 4'd1, 16'sh7FFF);
        send_beat(CMD_LOGIT, 4'd0, 16'sh7FFF);
        send_beat(CMD_LOGIT, 4'd15, 16'sh8000);
        send_beat(CMD_WEIGHT, 4'd0, 16'sh8000);
        send_beat(CMD_WEIGHT, 4'd1, 16'sh8000);
        send_beat(CMD_LOGIT, 4'd0, 16'sh0000);
        send_beat(CMD_LOGIT, 4'd0, 16'sh0000);
        send_beat(CMD_WEIGHT, 4'd15, 16'sh0100);
        // Weight written mid-anchor
        send_beat(CMD_LOGIT, 4'd0, 16'sh8000);
        send_beat(CMD_WEIGHT, 4'd1, 16'sh0300);
        send_beat(CMD_LOGIT, 4'd0, 16'sh7FFF);
        go_idle();
        // Bin count zero acts as one
        write_bins(5'd0);
        send_beat(CMD_LOGIT, 4'd0, 16'sh1234);
        go_idle();
        // Bin count above maximum acts as maximum
        write_bins(5'd31);
        for (int b = 0; b < MAX_BINS; b++) send_beat(CMD_LOGIT, 4'(b), 16'(b * 300));
        go_idle();
        // Bin count lowered mid-anchor
        write_bins(5'd16);
        for (int b = 0; b < 5; b++) send_beat(CMD_LOGIT, 4'd0, 16'(b * 100));
        in_ch.valid <= 1'b0;
        write_bins(5'd3);
        send_beat(CMD_LOGIT, 4'd0, 16'sh0050);
        go_idle();

        // Random phases across bin counts and idling patterns
        write_bins(5'd1);
        random_phase(60, 0, 0);
        write_bins(5'd4);
        random_phase(100, 54, 0);
        write_bins(5'd16);
        random_phase(100, 0, 54);
        write_bins(5'($urandom_range(2, 15)));
        random_phase(100, 16, 16);
        write_bins(5'd8);
        random_phase(60, 0, 0);

        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

### files.f
+incdir+src
src/sed_pkg.sv
src/sed_in_if.sv
src/sed_out_if.sv
src/sed_ctrl.sv
src/sed_dp.sv
src/softmax_expectation_decode.sv
tb/sed_checker.sv
tb/tb.sv
